// ===== src/c3zh_pkg.sv =====
// Package for the 3x3 zero-halo convolution block.
// Holds the shared constants, the configuration register codes and the structs
// that travel between the front end, the item queue and the back end.
package c3zh_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int MaxWidth  = 1024;
  localparam int PixelBits = 8;

  // Fixed port widths.
  localparam int PixelInW   = 8;
  localparam int OutWidth   = 19;
  localparam int CfgDataW   = 63;
  localparam int CfgIdxW    = 2;
  localparam int WidthRegW  = 11;
  localparam int HeightRegW = 13;
  localparam int TapW       = 7;
  localparam int NumTaps    = 9;

  // Register reset values: identity kernel, 5x5 image.
  localparam logic [CfgDataW-1:0]   TapsReset   = 63'd268435456;
  localparam logic [WidthRegW-1:0]  WidthReset  = 11'd5;
  localparam logic [HeightRegW-1:0] HeightReset = 13'd5;

  // Output saturation limits.
  localparam int OutMax = 262143;
  localparam int OutMin = -262144;

  // Queue between front and back.
  localparam int QueueDepth = 4;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KERNEL_TAPS  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } c3zh_cfg_e;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } c3zh_cfg_t;

  // Classification of one item, made by the front end.
  typedef struct packed {
    logic       out_ok;
    logic       eof;
    logic [2:0] row_ok;
    logic [2:0] col_ok;
  } c3zh_tag_t;

endpackage

// ===== src/conv3x3_zero_halo.sv =====
// Streaming 3x3 convolution with a one-pixel zero halo around the image.
// Pixel items enter on the in_* channel in raster order; each accepted item that
// is not ignored yields zero or one result on the out_* channel, in order.
// Results trail the inputs by one image row plus one pixel, so image_width + 1
// drain items (is_drain_i = 1) after the last pixel flush the last row; a drain
// item with no frame in progress is accepted and dropped.
// A result reaches the output register after the item that completes it passes
// the stage-one register, the item queue and the back-end stages b0 and b1.
// Throughput: one item per cycle while in_stall_o is low, set by the line store
// memory, read and written once per cycle with a bypass for the same column.
// The configuration port writes kernel_taps, image_width and image_height; width
// or height writes restart the frame position. Write only while the block is idle.
// Reset restores the identity kernel and a 5x5 image and empties the pipeline;
// the line store contents are not cleared and need no clearing pass, since the
// halo masking never reads an entry before the current frame has written it.
// When the receiver stalls, the result holds in its register, the back end stops and
// the four-entry queue fills; in_stall_o rises once queued and in-flight items fill it.
module conv3x3_zero_halo
  import c3zh_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidth,
  parameter int PIXEL_BITS = PixelBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [PixelInW-1:0]         pixel_i,
  input  logic                        is_drain_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [OutWidth-1:0]  filtered_o,
  output logic                        end_of_frame_o
);

  localparam int TagW   = $bits(c3zh_tag_t);
  localparam int EntryW = 3 * PIXEL_BITS + TagW;

  c3zh_cfg_t                 cfg;
  logic                      push, pop, q_empty;
  logic [QueueCntW-1:0]      q_count;
  logic [3*PIXEL_BITS-1:0]   push_col;
  c3zh_tag_t                 push_tag, head_tag;
  logic [EntryW-1:0]         head;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_data_i;

  c3zh_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_i    (pixel_i),
    .is_drain_i (is_drain_i),
    .q_count_i  (q_count),
    .push_o     (push),
    .push_col_o (push_col),
    .push_tag_o (push_tag)
  );

  c3zh_queue #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_col, push_tag}),
    .pop_i   (pop),
    .data_o  (head),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  assign head_tag = c3zh_tag_t'(head[TagW-1:0]);

  c3zh_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_empty_i      (q_empty),
    .head_col_i     (head[EntryW-1:TagW]),
    .head_tag_i     (head_tag),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .filtered_o     (filtered_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule

// ===== src/c3zh_queue.sv =====
// Short register queue that decouples the front end from the back end.
// Generic in width and depth; no package dependency.
module c3zh_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  logic [Width-1:0]               data_i,
  input  logic                           pop_i,
  output logic [Width-1:0]               data_o,
  output logic                           empty_o,
  output logic [$clog2(Depth+1)-1:0]     count_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign data_o  = entry_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

// ===== src/c3zh_front.sv =====
// Front end: accepts pixel items, tracks the frame position, classifies each item
// and keeps the two line stores. Uses c3zh_pkg; feeds c3zh_queue.
module c3zh_front
  import c3zh_pkg::*;
#(
  parameter int MAX_WIDTH  = MaxWidth,
  parameter int PIXEL_BITS = PixelBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  c3zh_cfg_t                   cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [PixelInW-1:0]         pixel_i,
  input  logic                        is_drain_i,
  input  logic [QueueCntW-1:0]        q_count_i,
  output logic                        push_o,
  output logic [3*PIXEL_BITS-1:0]     push_col_o,
  output c3zh_tag_t                   push_tag_o
);

  localparam int ColBits = $clog2(MAX_WIDTH);
  localparam int WidBits = $clog2(MAX_WIDTH + 1);
  localparam int OyW     = HeightRegW + 2;
  localparam logic signed [OyW-1:0] OneS = 1;
  localparam logic signed [OyW-1:0] TwoS = 2;

  logic [WidthRegW-1:0]    width_q;
  logic [HeightRegW-1:0]   height_q;
  logic [ColBits-1:0]      x_q, x_d, x_cur, ox;
  logic [HeightRegW-1:0]   y_q, y_d, y_cur, h_used;
  logic [WidBits-1:0]      w_used, x_inc;
  logic signed [OyW-1:0]   oy, y_ext, h_s;
  logic                    ignore, zero_px, accept, step;
  logic [PIXEL_BITS-1:0]   px;
  c3zh_tag_t               tag;
  logic [QueueCntW:0]      fill;

  logic                    s1_valid_q;
  logic [ColBits-1:0]      s1_x_q;
  logic [PIXEL_BITS-1:0]   s1_px_q;
  c3zh_tag_t               s1_tag_q;
  logic [2*PIXEL_BITS-1:0] rd_q;
  logic [2*PIXEL_BITS-1:0] wr_data;
  // Each entry holds {previous row, row before that} for one column.
  logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];

  always_comb begin
    if (width_q == '0) begin
      w_used = WidBits'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_used = WidBits'(MAX_WIDTH);
    end else begin
      w_used = WidBits'(width_q);
    end
    h_used = (height_q == '0) ? HeightRegW'(1) : height_q;
  end

  always_comb begin
    x_cur   = (WidBits'(x_q) >= w_used) ? '0 : x_q;
    y_cur   = (WidBits'(x_q) >= w_used) ? '0 : y_q;
    ignore  = is_drain_i && (x_cur == '0) && (y_cur == '0);
    zero_px = is_drain_i || (y_cur >= h_used);
    px      = zero_px ? '0 : PIXEL_BITS'(pixel_i);

    // The result position trails the input by one row and one pixel.
    y_ext = $signed({2'b00, y_cur});
    h_s   = $signed({2'b00, h_used});
    oy    = (x_cur != '0) ? y_ext - OneS : y_ext - TwoS;
    ox    = (x_cur != '0) ? x_cur - 1'b1 : ColBits'(w_used - WidBits'(1));

    tag.out_ok    = !oy[OyW-1] && (oy < h_s);
    tag.row_ok[0] = (oy >= OneS);
    tag.row_ok[1] = 1'b1;
    tag.row_ok[2] = ((oy + OneS) < h_s);
    tag.col_ok[0] = (ox != '0);
    tag.col_ok[1] = 1'b1;
    tag.col_ok[2] = ((WidBits'(ox) + WidBits'(1)) < w_used);
    tag.eof       = tag.out_ok && (oy == h_s - OneS) &&
                    (WidBits'(ox) == w_used - WidBits'(1));

    x_inc = WidBits'(x_cur) + WidBits'(1);
    if (tag.eof) begin
      x_d = '0;
      y_d = '0;
    end else if (x_inc == w_used) begin
      x_d = '0;
      y_d = y_cur + 1'b1;
    end else begin
      x_d = ColBits'(x_inc);
      y_d = y_cur;
    end
  end

  // Room is kept for the item in flight toward the queue.
  assign fill       = {1'b0, q_count_i} + {{QueueCntW{1'b0}}, s1_valid_q};
  assign in_stall_o = (fill >= (QueueCntW + 1)'(QueueDepth));
  assign accept     = in_valid_i && !in_stall_o;
  assign step       = accept && !ignore;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WidthReset;
      height_q   <= HeightReset;
      x_q        <= '0;
      y_q        <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= step;
      if (cfg_i.we && (cfg_i.index == CFG_IMAGE_WIDTH)) begin
        width_q <= cfg_i.data[WidthRegW-1:0];
        x_q     <= '0;
        y_q     <= '0;
      end else if (cfg_i.we && (cfg_i.index == CFG_IMAGE_HEIGHT)) begin
        height_q <= cfg_i.data[HeightRegW-1:0];
        x_q      <= '0;
        y_q      <= '0;
      end else if (step) begin
        x_q <= x_d;
        y_q <= y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      s1_x_q   <= x_cur;
      s1_px_q  <= px;
      s1_tag_q <= tag;
    end
  end

  assign wr_data = {s1_px_q, rd_q[2*PIXEL_BITS-1:PIXEL_BITS]};

  // The item one stage ahead writes the same column when the width is one or
  // right after the end of a frame, so its write data is passed straight on.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      line_mem[s1_x_q] <= wr_data;
    end
    if (step) begin
      rd_q <= (s1_valid_q && (s1_x_q == x_cur)) ? wr_data : line_mem[x_cur];
    end
  end

  assign push_o     = s1_valid_q;
  assign push_col_o = {s1_px_q, rd_q};
  assign push_tag_o = s1_tag_q;

endmodule

// ===== src/c3zh_back.sv =====
// Back end: shifts the 3x3 window, forms the nine masked tap products, sums and
// saturates them and holds the result for the receiver. Uses c3zh_pkg.
module c3zh_back
  import c3zh_pkg::*;
#(
  parameter int PIXEL_BITS = PixelBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  c3zh_cfg_t                   cfg_i,
  input  logic                        q_empty_i,
  input  logic [3*PIXEL_BITS-1:0]     head_col_i,
  input  c3zh_tag_t                   head_tag_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [OutWidth-1:0]  filtered_o,
  output logic                        end_of_frame_o
);

  localparam int PW     = PIXEL_BITS + 8;
  localparam int SumRaw = PW + 4;
  localparam int SumW   = (SumRaw > OutWidth) ? SumRaw : OutWidth + 1;
  localparam logic signed [SumW-1:0] SatMax = SumW'(OutMax);
  localparam logic signed [SumW-1:0] SatMin = SumW'(OutMin);

  logic [CfgDataW-1:0]          taps_q;
  logic [PIXEL_BITS-1:0]        win_q [NumTaps];
  logic                         advance;
  logic [NumTaps-1:0]           mask_d, b0_mask_q;
  logic                         b0_valid_q, b0_eof_q;
  logic signed [PW-1:0]         prod_d [NumTaps];
  logic signed [PW-1:0]         prod_q [NumTaps];
  logic                         b1_valid_q, b1_eof_q;
  logic signed [SumW-1:0]       sum;
  logic signed [OutWidth-1:0]   filt_d, filtered_q;
  logic                         out_valid_q, eof_q;

  // The whole back end moves together whenever the output register can take data.
  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance && !q_empty_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mask_d[r*3+c] = head_tag_i.row_ok[r] & head_tag_i.col_ok[c];
      end
    end
  end

  always_comb begin
    logic signed [PW-1:0] tap_x;
    logic signed [PW-1:0] pix_x;
    for (int k = 0; k < NumTaps; k++) begin
      tap_x = PW'($signed(taps_q[k*TapW +: TapW]));
      pix_x = PW'($signed({1'b0, win_q[k]}));
      prod_d[k] = b0_mask_q[k] ? tap_x * pix_x : '0;
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < NumTaps; k++) begin
      sum = sum + SumW'(prod_q[k]);
    end
    if (sum > SatMax) begin
      filt_d = OutWidth'(OutMax);
    end else if (sum < SatMin) begin
      filt_d = OutWidth'(OutMin);
    end else begin
      filt_d = OutWidth'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q      <= TapsReset;
      b0_valid_q  <= 1'b0;
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.we && (cfg_i.index == CFG_KERNEL_TAPS)) begin
        taps_q <= cfg_i.data;
      end
      if (advance) begin
        b0_valid_q  <= pop_o && head_tag_i.out_ok;
        b1_valid_q  <= b0_valid_q;
        out_valid_q <= b1_valid_q;
      end
    end
  end

  // Every popped item shifts the window, whether or not it yields a result.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3+0] <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= head_col_i[PIXEL_BITS-1:0];
      win_q[5] <= head_col_i[2*PIXEL_BITS-1:PIXEL_BITS];
      win_q[8] <= head_col_i[3*PIXEL_BITS-1:2*PIXEL_BITS];
    end
    if (advance) begin
      b0_mask_q  <= mask_d;
      b0_eof_q   <= head_tag_i.eof;
      prod_q     <= prod_d;
      b1_eof_q   <= b0_eof_q;
      filtered_q <= filt_d;
      eof_q      <= b1_eof_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign filtered_o     = filtered_q;
  assign end_of_frame_o = eof_q;

endmodule

// ===== src/c3zh_checker.sv =====
// Port-level checks for conv3x3_zero_halo, attached by the bind at the end.
// Uses c3zh_pkg for the result width.
module c3zh_checker
  import c3zh_pkg::*;
(
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic signed [OutWidth-1:0]  filtered_o,
  input logic                        end_of_frame_o
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_o) &&
                                   $stable(end_of_frame_o))
    else $error("stalled result changed or was withdrawn");

  // Reset empties the result pipeline.
  a_reset_out: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result offered right after reset");

  // Reset leaves the queue empty, so the input is open.
  a_reset_in: assert property (@(posedge clk_i) !rst_ni |=> !in_stall_o)
    else $error("input stalled right after reset");

  // Backpressure can only build up when an item has just come in.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without a new item");

endmodule

bind conv3x3_zero_halo c3zh_checker u_checker (.*);

// ===== tb/conv3x3_zero_halo_test.sv =====
// Self-checking testbench for conv3x3_zero_halo, the streaming 3x3 zero-halo convolution.
// A behavioral predictor in this file scores every result. It depends only on c3zh_pkg
// and the block itself.
module conv3x3_zero_halo_test;
  import c3zh_pkg::*;

  localparam int IdleGap       = 12;    // pipeline plus queue depth, with margin
  localparam int WatchdogLimit = 4000;
  localparam int IdlePct       = 32;
  localparam logic [PixelInW-1:0] PixMask  = PixelInW'((1 << PixelBits) - 1);
  localparam logic [CfgDataW-1:0] TapsMin  = {NumTaps{7'h40}};
  localparam logic [CfgDataW-1:0] TapsMax  = {NumTaps{7'h3F}};

  typedef struct {
    logic signed [OutWidth-1:0] filtered;
    logic                       eof;
  } conv_sum_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CfgIdxW-1:0]         cfg_index_i;
  logic [CfgDataW-1:0]        cfg_data_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [PixelInW-1:0]        pixel_i;
  logic                       is_drain_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [OutWidth-1:0] filtered_o;
  logic                       end_of_frame_o;

  conv3x3_zero_halo dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_i        (pixel_i),
    .is_drain_i     (is_drain_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .filtered_o     (filtered_o),
    .end_of_frame_o (end_of_frame_o)
  );

  // Predictor state: registers, line stores, window and input position.
  logic [CfgDataW-1:0]   taps_q;
  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic [7:0]            prev_row  [MaxWidth];
  logic [7:0]            older_row [MaxWidth];
  logic [7:0]            nbhd      [9];
  int                    frame_col;
  int                    frame_row;

  conv_sum_t sums_due [$];
  int        mismatches;
  int        sums_checked;
  int        items_taken;
  int        settings_run;
  int        quiet_cycles;
  int        sink_hold;
  bit        steady;
  int        fw;
  int        fh;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int tap_at(input int k);
    logic signed [TapW-1:0] t;
    t = taps_q[TapW*k +: TapW];
    return int'(t);
  endfunction

  // Moves one accepted item through the window and queues the sum it completes, if any.
  function automatic void convolve_item(input logic [PixelInW-1:0] px_in, input logic drain);
    int         w, h, x, y, ox, oy, acc, r, c, ry, cx;
    logic [7:0] px;
    conv_sum_t  sum;
    w = (width_q == 0) ? 1 : ((width_q > MaxWidth) ? MaxWidth : int'(width_q));
    h = (height_q == 0) ? 1 : int'(height_q);
    x = frame_col;
    y = frame_row;
    if (x >= w) begin
      x = 0;
      y = 0;
    end
    // A drain with no frame in progress leaves everything as it is.
    if (drain && x == 0 && y == 0) return;
    items_taken++;
    px = (drain || y >= h) ? 8'd0 : (px_in & PixMask);
    for (r = 0; r < 3; r++) begin
      nbhd[r*3]   = nbhd[r*3+1];
      nbhd[r*3+1] = nbhd[r*3+2];
    end
    nbhd[2]      = older_row[x];
    nbhd[5]      = prev_row[x];
    nbhd[8]      = px;
    older_row[x] = prev_row[x];
    prev_row[x]  = px;
    if (x >= 1) begin
      ox = x - 1;
      oy = y - 1;
    end else begin
      ox = w - 1;
      oy = y - 2;
    end
    x++;
    if (x == w) begin
      x = 0;
      y++;
    end
    frame_col = x;
    frame_row = y & 13'h1FFF;
    if (oy < 0 || oy >= h) return;
    acc = 0;
    for (r = 0; r < 3; r++) begin
      ry = oy + r - 1;
      if (ry >= 0 && ry < h) begin
        for (c = 0; c < 3; c++) begin
          cx = ox + c - 1;
          if (cx >= 0 && cx < w) acc += tap_at(r*3 + c) * int'(nbhd[r*3 + c]);
        end
      end
    end
    if (acc > OutMax) acc = OutMax;
    if (acc < OutMin) acc = OutMin;
    sum.filtered = acc[OutWidth-1:0];
    sum.eof      = (oy == h - 1 && ox == w - 1);
    if (sum.eof) begin
      frame_col = 0;
      frame_row = 0;
    end
    sums_due.push_back(sum);
  endfunction

  // Register writes and accepted items update the predictor.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (c3zh_cfg_e'(cfg_index_i))
          CFG_KERNEL_TAPS: taps_q = cfg_data_i;
          CFG_IMAGE_WIDTH: begin
            width_q   = cfg_data_i[WidthRegW-1:0];
            frame_col = 0;
            frame_row = 0;
          end
          CFG_IMAGE_HEIGHT: begin
            height_q  = cfg_data_i[HeightRegW-1:0];
            frame_col = 0;
            frame_row = 0;
          end
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) convolve_item(pixel_i, is_drain_i);
    end
  end

  always @(posedge clk_i) begin
    conv_sum_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sums_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: expected nothing, got filtered %0d eof %0b",
                 $time, filtered_o, end_of_frame_o);
      end else begin
        due = sums_due.pop_front();
        sums_checked++;
        if (filtered_o !== due.filtered) begin
          mismatches++;
          $display("%0t: filtered mismatch: expected %0d, got %0d",
                   $time, due.filtered, filtered_o);
        end
        if (end_of_frame_o !== due.eof) begin
          mismatches++;
          $display("%0t: end_of_frame mismatch: expected %0b, got %0b",
                   $time, due.eof, end_of_frame_o);
        end
      end
    end
  end

  // Receiver: random stalls, none in steady stretches; a hold-off when asked beats both.
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      out_stall_i = 1'b1;
      sink_hold--;
    end else if (steady) begin
      out_stall_i = 1'b0;
    end else begin
      out_stall_i = ($urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("conv3x3_zero_halo_test failed");
        $finish;
      end
    end
  end

  task automatic offer_item(input logic [PixelInW-1:0] px, input logic drain);
    @(negedge clk_i);
    if (!steady) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i = 1'b1;
    pixel_i    = px;
    is_drain_i = drain;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stops sending and waits until every queued result has come out.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (IdleGap) @(posedge clk_i);
  endtask

  task automatic write_reg(input c3zh_cfg_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    in_valid_i  = 1'b0;
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic configure(input logic [CfgDataW-1:0] taps, input int w, input int h);
    write_reg(CFG_KERNEL_TAPS, taps);
    write_reg(CFG_IMAGE_WIDTH, CfgDataW'(w));
    write_reg(CFG_IMAGE_HEIGHT, CfgDataW'(h));
    fw = (w == 0) ? 1 : ((w > MaxWidth) ? MaxWidth : w);
    fh = (h == 0) ? 1 : h;
    settings_run++;
  endtask

  function automatic logic [PixelInW-1:0] pick_pixel();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return PixelInW'($urandom_range(255));
  endfunction

  function automatic logic [CfgDataW-1:0] random_taps();
    return CfgDataW'({$urandom, $urandom});
  endfunction

  // One frame followed by its halo row. Drains may replace pixels inside the frame and
  // real pixels may stand in for halo items. A frame can be cut short at abort_at.
  task automatic send_frame(input int drain_pct, input int halo_px_pct, input int fixed_px,
                            input int abort_at);
    int i;
    logic [PixelInW-1:0] px;
    for (i = 0; i < fw * fh; i++) begin
      if (i == abort_at) return;
      px = (fixed_px < 0) ? pick_pixel() : PixelInW'(fixed_px);
      offer_item(px, i != 0 && $urandom_range(99) < drain_pct);
    end
    for (i = 0; i <= fw; i++) offer_item(pick_pixel(), $urandom_range(99) >= halo_px_pct);
  endtask

  task automatic test_reset_defaults();
    // Identity kernel on a 5x5 image, straight out of reset. The leading drain is dropped.
    fw = 5;
    fh = 5;
    offer_item(pick_pixel(), 1'b1);
    send_frame(10, 30, -1, -1);
    settle();
  endtask

  task automatic test_tap_extremes();
    configure(TapsMin, 3, 3);
    send_frame(0, 0, 255, -1);
    settle();
    configure(TapsMax, 3, 3);
    send_frame(0, 0, 255, -1);
    settle();
  endtask

  task automatic test_restart_mid_frame();
    configure(random_taps(), 4, 3);
    send_frame(0, 0, -1, 6);
    // The sender waits here until every result so far is out, then changes the kernel.
    settle();
    write_reg(CFG_KERNEL_TAPS, random_taps());
    offer_item(pick_pixel(), 1'b0);
    offer_item(pick_pixel(), 1'b1);
    settle();
    // A size write restarts the frame while the line stores keep old rows.
    configure(random_taps(), 3, 3);
    send_frame(0, 0, -1, -1);
    settle();
  endtask

  task automatic test_size_extremes();
    configure(random_taps(), 0, 0);
    send_frame(0, 0, -1, -1);
    settle();
    configure(random_taps(), 1, 1);
    send_frame(0, 50, -1, -1);
    settle();
    // Width 2047, heights 4095, 4096: only started; the next size write restarts them.
    configure(random_taps(), (1 << WidthRegW) - 1, 1);
    send_frame(5, 10, -1, 30);
    settle();
    configure(random_taps(), 1, 4095);
    send_frame(5, 0, -1, 30);
    settle();
    configure(random_taps(), 1, 4096);
    send_frame(5, 0, -1, 30);
    settle();
  endtask

  task automatic test_full_rate();
    configure(random_taps(), 16, 6);
    steady = 1'b1;
    send_frame(0, 0, -1, -1);
    steady = 1'b0;
    settle();
  endtask

  task automatic test_backpressure();
    configure(random_taps(), 12, 4);
    steady    = 1'b1;
    sink_hold = 200;
    send_frame(0, 0, -1, -1);
    steady = 1'b0;
    settle();
  endtask

  task automatic test_random_frames();
    int start, nframes, f, r, w, h;
    start = items_taken;
    while (items_taken - start < 100) begin
      settle();
      r = $urandom_range(99);
      w = (r < 5) ? 0 : ((r < 15) ? $urandom_range(13, 40) : $urandom_range(1, 10));
      h = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 6);
      configure(random_taps(), w, h);
      nframes = $urandom_range(1, 3);
      for (f = 0; f < nframes; f++) begin
        if ($urandom_range(99) < 8) begin
          send_frame(5, 15, -1, $urandom_range(fw * fh - 1));
          break;
        end
        send_frame(5, 15, -1, -1);
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 3)) offer_item(pick_pixel(), 1'b1);
        end
      end
    end
    settle();
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_KERNEL_TAPS;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    pixel_i      = '0;
    is_drain_i   = 1'b0;
    out_stall_i  = 1'b0;
    steady       = 1'b0;
    sink_hold    = 0;
    mismatches   = 0;
    sums_checked = 0;
    items_taken  = 0;
    settings_run = 0;
    quiet_cycles = 0;
    taps_q       = TapsReset;
    width_q      = WidthReset;
    height_q     = HeightReset;
    frame_col    = 0;
    frame_row    = 0;
    for (int i = 0; i < MaxWidth; i++) begin
      prev_row[i]  = '0;
      older_row[i] = '0;
    end
    for (int i = 0; i < 9; i++) nbhd[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_tap_extremes();
    test_restart_mid_frame();
    test_size_extremes();
    test_full_rate();
    test_backpressure();
    test_random_frames();

    $display("Run covered %0d frame items over %0d register settings, including size extremes,",
             items_taken, settings_run);
    $display("backpressure and restarts; %0d sums checked, %0d mismatches.",
             sums_checked, mismatches);
    if (mismatches == 0) begin
      $display("conv3x3_zero_halo_test passed");
    end else begin
      $display("conv3x3_zero_halo_test failed");
    end
    $finish;
  end

endmodule
